// ===== hw/rtl/pkcs7_pad_unpad_stream_core_assert.svh =====
// Assertion helpers for the padding core; expect clk and rst_n in scope.
`ifndef PKCS7_PAD_UNPAD_STREAM_CORE_ASSERT_SVH
`define PKCS7_PAD_UNPAD_STREAM_CORE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define PKCS7_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkcs7 core: same-cycle check failed");

// Condition holds in the cycle after the trigger.
`define PKCS7_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkcs7 core: next-cycle check failed");

`endif

// ===== hw/rtl/pkcs7_pkg.sv =====
package pkcs7_pkg;

    localparam int MAX_BLOCK_DEF = 32;
    localparam int DATA_W        = 8;
    localparam int BB_W          = 6;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;
    localparam logic [BB_W-1:0] BLOCK_BYTES_RST = BB_W'(16);

    // Register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_PAD_MODE    = 1'b0,
        REG_BLOCK_BYTES = 1'b1
    } reg_idx_t;

    // Sequencer steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_U_CHK,
        ST_U_RD,
        ST_U_REL,
        ST_U_WR,
        ST_U_END,
        ST_U_FRD,
        ST_U_FEM,
        ST_U_EMPTY,
        ST_P_PAD
    } step_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_MEM,
        EM_PAD,
        EM_EMPTY
    } emit_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_SKIP_REL,
        C_NOT_END,
        C_KEEP_ZERO,
        C_NOT_LAST,
        C_DISPATCH
    } cond_t;

    // One control word: jump to jmp when cond is true, else go to nxt
    typedef struct packed {
        emit_t emit;
        logic  tail;
        logic  rd;
        logic  adv;
        logic  dec_count;
        logic  dec_cnt;
        logic  push;
        logic  eval;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } ucw_t;

    localparam ucw_t UW_IDLE = '{emit: EM_NONE, tail: 1'b0, rd: 1'b0, adv: 1'b0,
        dec_count: 1'b0, dec_cnt: 1'b0, push: 1'b0, eval: 1'b0,
        cond: C_DISPATCH, jmp: ST_IDLE, nxt: ST_IDLE};

    function automatic ucw_t ucode_rom(step_t s);
        ucw_t w;
        w = UW_IDLE;
        unique case (s)
            ST_IDLE:
            begin
                w = UW_IDLE;
            end
            ST_U_CHK:
            begin
                w.cond = C_SKIP_REL;
                w.jmp  = ST_U_WR;
                w.nxt  = ST_U_RD;
            end
            ST_U_RD:
            begin
                w.rd   = 1'b1;
                w.cond = C_ALWAYS;
                w.jmp  = ST_U_REL;
                w.nxt  = ST_U_REL;
            end
            ST_U_REL:
            begin
                w.emit      = EM_MEM;
                w.adv       = 1'b1;
                w.dec_count = 1'b1;
                w.cond      = C_ALWAYS;
                w.jmp       = ST_U_CHK;
                w.nxt       = ST_U_CHK;
            end
            ST_U_WR:
            begin
                w.push = 1'b1;
                w.cond = C_NOT_END;
                w.jmp  = ST_IDLE;
                w.nxt  = ST_U_END;
            end
            ST_U_END:
            begin
                w.eval = 1'b1;
                w.cond = C_KEEP_ZERO;
                w.jmp  = ST_U_EMPTY;
                w.nxt  = ST_U_FRD;
            end
            ST_U_FRD:
            begin
                w.rd   = 1'b1;
                w.cond = C_ALWAYS;
                w.jmp  = ST_U_FEM;
                w.nxt  = ST_U_FEM;
            end
            ST_U_FEM:
            begin
                w.emit    = EM_MEM;
                w.tail    = 1'b1;
                w.adv     = 1'b1;
                w.dec_cnt = 1'b1;
                w.cond    = C_NOT_LAST;
                w.jmp     = ST_U_FRD;
                w.nxt     = ST_IDLE;
            end
            ST_U_EMPTY:
            begin
                w.emit = EM_EMPTY;
                w.cond = C_ALWAYS;
                w.jmp  = ST_IDLE;
                w.nxt  = ST_IDLE;
            end
            ST_P_PAD:
            begin
                w.emit    = EM_PAD;
                w.tail    = 1'b1;
                w.dec_cnt = 1'b1;
                w.cond    = C_NOT_LAST;
                w.jmp     = ST_P_PAD;
                w.nxt     = ST_IDLE;
            end
            default:
            begin
                w = UW_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/pkcs7_in_if.sv =====
interface pkcs7_in_if;
    import pkcs7_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_in;
    logic              byte_valid;
    logic              msg_end;

    modport source (output valid, data_in, byte_valid, msg_end, input ready);
    modport sink   (input valid, data_in, byte_valid, msg_end, output ready);
endinterface

// ===== hw/rtl/pkcs7_out_if.sv =====
interface pkcs7_out_if;
    import pkcs7_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              out_valid;
    logic              out_end;
    logic              pad_stripped;

    modport source (output valid, data_out, out_valid, out_end, pad_stripped, input ready);
    modport sink   (input valid, data_out, out_valid, out_end, pad_stripped, output ready);
endinterface

// ===== hw/rtl/pkcs7_pad_unpad_stream_core.sv =====
// Block-cipher padding core: adds padding (pad_mode 0) or checks and strips it (pad_mode 1).
// msg_ch takes one message byte per transfer; byte_valid 0 with msg_end 1 ends a message
// without a byte. res_ch returns bytes, with out_end on the last result of each message and
// pad_stripped on that result when unpad mode removed a valid pad run.
// The APB port holds pad_mode (0x0) and block_bytes (0x4); write them only while idle.
// Pad mode: one byte per cycle while the receiver keeps up, result registered in the cycle
// after the transfer; the end flush then emits one pad byte per cycle while the receiver
// takes them, from the microcode step that counts them down. Unpad mode: each byte takes
// a check and a write step, and each byte pushed out of the hold buffer first takes a read,
// a release and a check step; the end flush takes an evaluation step and then, per released
// byte, one registered read of the hold memory and one emit step. Before a pad-mode item
// after a block size change, phase is reduced by one subtraction per cycle until it is
// below the block size. Reset clears the sequencer, counters and output register and
// loads pad_mode 0 and block_bytes 16; no clearing pass is needed. A stalled receiver
// holds the result register; the sequencer waits on each emit step and, in pad mode,
// msg_ch.ready drops until the result is taken.
`include "pkcs7_pad_unpad_stream_core_assert.svh"

module pkcs7_pad_unpad_stream_core #(
    parameter int MAX_BLOCK = pkcs7_pkg::MAX_BLOCK_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pkcs7_pkg::APB_AW-1:0]  paddr,
    input  logic [pkcs7_pkg::APB_DW-1:0]  pwdata,
    output logic [pkcs7_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    pkcs7_in_if.sink                      msg_ch,
    pkcs7_out_if.source                   res_ch
);
    import pkcs7_pkg::*;

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam logic [CW-1:0]   MAXB      = CW'(MAX_BLOCK);
    localparam logic [CW-1:0]   ONE_C     = CW'(1);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(MAX_BLOCK - 1);
    localparam logic [AW:0]     DEPTH_X   = (AW + 1)'(MAX_BLOCK);
    localparam logic [BB_W-1:0] MAXB_BB   = BB_W'(MAX_BLOCK);

    // Configuration registers
    logic            pad_mode_reg;
    logic [BB_W-1:0] block_bytes_reg;

    // Sequencer
    step_t step_reg;
    step_t step_next;
    ucw_t  uw;

    // Hold buffer: ring of bytes, oldest at head
    logic [DATA_W-1:0] mem [MAX_BLOCK];
    logic [DATA_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     wr_addr;
    logic [AW:0]       wr_sum;
    logic [AW-1:0]     head_inc;

    logic [AW-1:0]     head_reg,   head_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [CW-1:0]     run_reg,    run_next;    // trailing bytes equal to last_reg
    logic [DATA_W-1:0] last_reg,   last_next;
    logic [AW-1:0]     phase_reg,  phase_next;
    logic [CW-1:0]     cnt_reg,    cnt_next;    // results left in the end flush
    logic [CW-1:0]     npad_reg,   npad_next;
    logic              strip_reg,  strip_next;

    logic [DATA_W-1:0] lat_data_reg,  lat_data_next;
    logic              lat_valid_reg, lat_valid_next;
    logic              lat_end_reg,   lat_end_next;

    // Result register
    logic              ov_reg,     ov_next;
    logic [DATA_W-1:0] od_reg,     od_next;
    logic              oval_reg,   oval_next;
    logic              oend_reg,   oend_next;
    logic              ostrip_reg, ostrip_next;

    logic          slot_free;
    logic          step_go;
    logic          acc;
    logic          norm_need;
    logic [CW-1:0] b_eff;
    logic [CW-1:0] phase_inc;
    logic [CW-1:0] phase_new;
    logic [CW-1:0] npad;
    logic          pad_ok;
    logic [CW-1:0] keep;
    logic [CW-1:0] count_dec;
    logic          skip_rel;
    logic          last_one;
    logic          cfg_wr;
    reg_idx_t      reg_sel;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_mode_reg    <= 1'b0;
            block_bytes_reg <= BLOCK_BYTES_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_PAD_MODE:    pad_mode_reg    <= pwdata[0];
                REG_BLOCK_BYTES: block_bytes_reg <= pwdata[BB_W-1:0];
                default:         pad_mode_reg    <= pad_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_PAD_MODE:    prdata[0]      = pad_mode_reg;
            REG_BLOCK_BYTES: prdata[BB_W-1:0] = block_bytes_reg;
            default:         prdata         = '0;
        endcase
    end

    // Block size clamped to 1..MAX_BLOCK
    always_comb
    begin
        if (block_bytes_reg == '0)
        begin
            b_eff = ONE_C;
        end
        else if (block_bytes_reg > MAXB_BB)
        begin
            b_eff = MAXB;
        end
        else
        begin
            b_eff = CW'(block_bytes_reg);
        end
    end

    // ---------------------------------------------------------------
    // Shared datapath terms
    // ---------------------------------------------------------------
    assign uw        = ucode_rom(step_reg);
    assign slot_free = !ov_reg || res_ch.ready;
    assign step_go   = (uw.emit == EM_NONE) || slot_free;
    assign norm_need = CW'(phase_reg) >= b_eff;

    assign msg_ch.ready = (step_reg == ST_IDLE) &&
                          (pad_mode_reg ? 1'b1 : (slot_free && !norm_need));
    assign acc = msg_ch.valid && msg_ch.ready;

    // Pad mode: advance phase mod B, pad count from the new phase
    assign phase_inc = CW'(phase_reg) + ONE_C;
    assign phase_new = msg_ch.byte_valid ? ((phase_inc == b_eff) ? '0 : phase_inc)
                                         : CW'(phase_reg);
    assign npad      = b_eff - phase_new;

    // Unpad check: last byte is the pad count, run covers the pad bytes
    assign pad_ok = (count_reg != '0) && (last_reg != '0) &&
                    (last_reg <= DATA_W'(b_eff)) && (last_reg <= DATA_W'(count_reg)) &&
                    (DATA_W'(run_reg) >= last_reg);
    assign keep   = pad_ok ? (count_reg - CW'(last_reg)) : count_reg;

    assign count_dec = count_reg - ONE_C;
    assign skip_rel  = !(lat_valid_reg && (count_reg >= b_eff));
    assign last_one  = (cnt_reg == ONE_C);

    assign head_inc = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);
    assign wr_sum   = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
    assign wr_addr  = (wr_sum >= DEPTH_X) ? AW'(wr_sum - DEPTH_X) : AW'(wr_sum);

    // ---------------------------------------------------------------
    // Next step
    // ---------------------------------------------------------------
    always_comb
    begin
        step_next = step_reg;
        if (step_reg == ST_IDLE)
        begin
            if (acc)
            begin
                if (pad_mode_reg)
                begin
                    if (msg_ch.byte_valid || msg_ch.msg_end)
                    begin
                        step_next = ST_U_CHK;
                    end
                end
                else if (msg_ch.msg_end)
                begin
                    step_next = ST_P_PAD;
                end
            end
        end
        else if (step_go)
        begin
            unique case (uw.cond)
                C_ALWAYS:    step_next = uw.jmp;
                C_SKIP_REL:  step_next = skip_rel ? uw.jmp : uw.nxt;
                C_NOT_END:   step_next = !lat_end_reg ? uw.jmp : uw.nxt;
                C_KEEP_ZERO: step_next = (keep == '0) ? uw.jmp : uw.nxt;
                C_NOT_LAST:  step_next = !last_one ? uw.jmp : uw.nxt;
                C_DISPATCH:  step_next = step_reg;
                default:     step_next = ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath controls from the current step
    // ---------------------------------------------------------------
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        run_next       = run_reg;
        last_next      = last_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        npad_next      = npad_reg;
        strip_next     = strip_reg;
        lat_data_next  = lat_data_reg;
        lat_valid_next = lat_valid_reg;
        lat_end_next   = lat_end_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        ov_next        = ov_reg && !res_ch.ready;
        od_next        = od_reg;
        oval_next      = oval_reg;
        oend_next      = oend_reg;
        ostrip_next    = ostrip_reg;

        if (step_reg == ST_IDLE)
        begin
            // Reduce a stale phase after a block size change
            if (!pad_mode_reg && norm_need)
            begin
                phase_next = AW'(CW'(phase_reg) - b_eff);
            end
            if (acc)
            begin
                if (pad_mode_reg)
                begin
                    lat_data_next  = msg_ch.data_in;
                    lat_valid_next = msg_ch.byte_valid;
                    lat_end_next   = msg_ch.msg_end;
                end
                else
                begin
                    // Pad mode: drop anything held, pass the byte straight out
                    count_next = '0;
                    phase_next = msg_ch.msg_end ? '0 : AW'(phase_new);
                    cnt_next   = npad;
                    npad_next  = npad;
                    if (msg_ch.byte_valid)
                    begin
                        ov_next     = 1'b1;
                        od_next     = msg_ch.data_in;
                        oval_next   = 1'b1;
                        oend_next   = 1'b0;
                        ostrip_next = 1'b0;
                    end
                end
            end
        end
        else if (step_go)
        begin
            if (uw.emit != EM_NONE)
            begin
                ov_next = 1'b1;
            end
            case (uw.emit)
                EM_MEM:
                begin
                    od_next     = rdata_reg;
                    oval_next   = 1'b1;
                    oend_next   = uw.tail && last_one;
                    ostrip_next = uw.tail && last_one && strip_reg;
                end
                EM_PAD:
                begin
                    od_next     = DATA_W'(npad_reg);
                    oval_next   = 1'b1;
                    oend_next   = uw.tail && last_one;
                    ostrip_next = 1'b0;
                end
                EM_EMPTY:
                begin
                    od_next     = '0;
                    oval_next   = 1'b0;
                    oend_next   = 1'b1;
                    ostrip_next = strip_reg;
                end
                default:
                begin
                    od_next = od_reg;
                end
            endcase

            mem_re = uw.rd;
            if (uw.adv)
            begin
                head_next = head_inc;
            end
            if (uw.dec_count)
            begin
                count_next = count_dec;
                run_next   = (run_reg > count_dec) ? count_dec : run_reg;
            end
            if (uw.dec_cnt)
            begin
                cnt_next = cnt_reg - ONE_C;
            end
            if (uw.push && lat_valid_reg)
            begin
                mem_we     = 1'b1;
                count_next = count_reg + ONE_C;
                last_next  = lat_data_reg;
                run_next   = ((count_reg != '0) && (lat_data_reg == last_reg)) ?
                             (run_reg + ONE_C) : ONE_C;
            end
            if (uw.eval)
            begin
                // Result decided; buffer is drained from head by count in cnt
                cnt_next   = keep;
                strip_next = pad_ok;
                count_next = '0;
                phase_next = '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            run_reg   <= '0;
            phase_reg <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        npad_reg      <= npad_next;
        strip_reg     <= strip_next;
        lat_data_reg  <= lat_data_next;
        lat_valid_reg <= lat_valid_next;
        lat_end_reg   <= lat_end_next;
        od_reg        <= od_next;
        oval_reg      <= oval_next;
        oend_reg      <= oend_next;
        ostrip_reg    <= ostrip_next;
    end

    // Hold memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= lat_data_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign res_ch.valid        = ov_reg;
    assign res_ch.data_out     = od_reg;
    assign res_ch.out_valid    = oval_reg;
    assign res_ch.out_end      = oend_reg;
    assign res_ch.pad_stripped = ostrip_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PKCS7_ASSERT_HOLDS(a_count_bound, 1'b1, count_reg <= MAXB)
    `PKCS7_ASSERT_HOLDS(a_run_le_count, count_reg != '0, run_reg <= count_reg)
    `PKCS7_ASSERT_HOLDS(a_pad_cnt_live, step_reg == ST_P_PAD, cnt_reg != '0)
    `PKCS7_ASSERT_NEXT(a_pad_end_flush, acc && !pad_mode_reg && msg_ch.msg_end, step_reg == ST_P_PAD)

endmodule

// ===== verif/tb.sv =====
module tb;
    import pkcs7_pkg::*;

    // One result transfer as seen on res_ch
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       stripped;
    } pad_res_t;

    // Shapes of an unpad-mode message body
    typedef enum int {
        SH_GOOD,
        SH_BAD_RUN,
        SH_ZERO_COUNT,
        SH_BIG_COUNT,
        SH_SHORT_RUN,
        SH_RAW
    } shape_t;

    // Padding predictor: mirrors the register file and the hold line, and queues
    // the result bytes each accepted message transfer is owed.
    class pad_stream_model;
        logic        unpad;
        logic [5:0]  blk_reg;
        logic [7:0]  held[$];
        int unsigned phase;
        pad_res_t    owed[$];
        int          errors;

        function new();
            unpad   = 1'b0;
            blk_reg = BLOCK_BYTES_RST;
            phase   = 0;
            errors  = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [5:0] v);
            if (idx == REG_PAD_MODE)
                unpad = v[0];
            else
                blk_reg = v;
        endfunction

        // Block size as the core uses it: 0 acts as 1, above the maximum clamps
        function int unsigned eff_block();
            if (blk_reg == 0)
                return 1;
            if (blk_reg > MAX_BLOCK_DEF)
                return MAX_BLOCK_DEF;
            return blk_reg;
        endfunction

        function void owe(logic [7:0] d, logic present, logic last, logic stripped);
            owed.push_back(pad_res_t'{d, present, last, stripped});
        endfunction

        function void take_byte(logic [7:0] d, logic has_byte, logic last);
            int unsigned b;
            int unsigned npad;
            int unsigned cnt;
            int unsigned keep;
            int unsigned p;
            logic        ok;
            logic        stripped;
            b = eff_block();
            if (!unpad)
            begin
                // pad mode: anything held from an unpad start is dropped
                held.delete();
                if (has_byte)
                begin
                    owe(d, 1'b1, 1'b0, 1'b0);
                    phase = ((phase % b) + 1) % b;
                end
                if (last)
                begin
                    npad = b - (phase % b);
                    for (int i = 0; i < npad; i++)
                        owe(8'(npad), 1'b1, i == npad - 1, 1'b0);
                    phase = 0;
                end
                return;
            end
            if (has_byte)
            begin
                while (held.size() >= b)
                    owe(held.pop_front(), 1'b1, 1'b0, 1'b0);
                held.push_back(d);
            end
            if (!last)
                return;
            cnt      = held.size();
            keep     = cnt;
            stripped = 1'b0;
            if (cnt > 0)
            begin
                p  = held[cnt-1];
                ok = (p != 0) && (p <= b) && (p <= cnt);
                for (int i = 0; ok && i < p; i++)
                    if (held[cnt-1-i] != p)
                        ok = 1'b0;
                if (ok)
                begin
                    keep     = cnt - p;
                    stripped = 1'b1;
                end
            end
            if (keep == 0)
                owe(8'h00, 1'b0, 1'b1, stripped);
            else
                for (int i = 0; i < keep; i++)
                    owe(held[i], 1'b1, i == keep - 1, (i == keep - 1) && stripped);
            held.delete();
            phase = 0;
        endfunction

        function void match_result(pad_res_t got);
            pad_res_t want;
            if (owed.size() == 0)
            begin
                $error("unexpected result: data_out %0h out_valid %0b out_end %0b pad_stripped %0b",
                       got.data, got.present, got.last, got.stripped);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.data !== want.data)
            begin
                $error("data_out: expected %0h, got %0h", want.data, got.data);
                errors++;
            end
            if (got.present !== want.present)
            begin
                $error("out_valid: expected %0b, got %0b", want.present, got.present);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("out_end: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
            if (got.stripped !== want.stripped)
            begin
                $error("pad_stripped: expected %0b, got %0b", want.stripped, got.stripped);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    pkcs7_in_if  msg_if ();
    pkcs7_out_if res_if ();

    pad_stream_model sb = new();

    int burst_left = 0;   // transfers left in the current sender burst
    int sent       = 0;   // message transfers that carry a byte or an end
    bit steady     = 0;   // phase where the sender never idles

    pkcs7_pad_unpad_stream_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .msg_ch  (msg_if),
        .res_ch  (res_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #40000000;
        $display("FAIL pkcs7_pad_unpad_stream_core");
        $finish;
    end

    // Sample both channels at the edge; results first, since a result never
    // belongs to the transfer accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.match_result(pad_res_t'{res_if.data_out, res_if.out_valid,
                                       res_if.out_end, res_if.pad_stripped});
        if (rst_n && msg_if.valid && msg_if.ready)
            sb.take_byte(msg_if.data_in, msg_if.byte_valid, msg_if.msg_end);
    end

    // Receiver back-pressure: switch between styles over random spans -- always ready,
    // mostly ready, ready when the span counter is a multiple of three, and random stalls.
    initial
    begin
        int style;
        int span;
        int stall;
        res_if.ready = 1'b0;
        style = 0;
        span  = 0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(50, 300);
            end
            span--;
            case (style)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 3) != 0);
                2: res_if.ready <= (span % 3 == 0);
                default:
                begin
                    if (stall > 0)
                    begin
                        stall--;
                        res_if.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 5) == 0)
                    begin
                        stall = $urandom_range(1, 8);
                        res_if.ready <= 1'b0;
                    end
                    else
                    begin
                        res_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Write one register: setup cycle, then access cycle until pready; mirror
    // the value into the predictor once the write has landed.
    task automatic apb_write(input reg_idx_t idx, input logic [5:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Offer one message transfer and hold it until accepted. Open a new burst
    // when the old one runs out, idling the channel for a random gap first.
    task automatic put_item(input logic [7:0] d, input logic has_byte, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                msg_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        msg_if.valid      <= 1'b1;
        msg_if.data_in    <= d;
        msg_if.byte_valid <= has_byte;
        msg_if.msg_end    <= last;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        if (has_byte || last)
            sent++;
    endtask

    // Drop valid, wait for every owed result, then give the core time to finish
    // any transfer that produced nothing.
    task automatic drain_results();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    // Block size for a phase: mostly small, with the clamped codes now and then
    function automatic logic [5:0] pick_block();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 6'd0;
        if (r == 1)
            return 6'd63;
        if (r == 2)
            return 6'($urandom_range(33, 62));
        if (r == 3)
            return 6'd1;
        if (r == 4)
            return 6'd32;
        if (r < 14)
            return 6'($urandom_range(2, 8));
        return 6'($urandom_range(1, 32));
    endfunction

    task automatic directed_items();
        // empty message right after reset: pad mode, block 16 -> one full pad block
        put_item(8'h00, 1'b0, 1'b1);
        // extreme byte values, with an ignored empty transfer in the middle
        put_item(8'h00, 1'b1, 1'b0);
        put_item(8'hA5, 1'b0, 1'b0);
        put_item(8'hFF, 1'b1, 1'b1);
        // block code 0 acts as one byte: an aligned message still gets a pad byte
        drain_results();
        apb_write(REG_BLOCK_BYTES, 6'd0);
        put_item(8'h5A, 1'b1, 1'b1);
        // top block code clamps to the maximum: empty message -> full max block
        drain_results();
        apb_write(REG_BLOCK_BYTES, 6'd63);
        put_item(8'h00, 1'b0, 1'b1);
        // block size changed mid-message in pad mode: phase 2 is already below the new size 3
        drain_results();
        apb_write(REG_BLOCK_BYTES, 6'd4);
        put_item(8'h11, 1'b1, 1'b0);
        put_item(8'h22, 1'b1, 1'b0);
        drain_results();
        apb_write(REG_BLOCK_BYTES, 6'd3);
        put_item(8'h33, 1'b1, 1'b1);
        // unpad mode, block 4
        drain_results();
        apb_write(REG_PAD_MODE, 6'd1);
        apb_write(REG_BLOCK_BYTES, 6'd4);
        // empty message -> empty end marker, nothing stripped
        put_item(8'h00, 1'b0, 1'b1);
        // padding covers every held byte -> empty end marker with strip set
        repeat (4) put_item(8'h04, 1'b1, 1'b0);
        put_item(8'h00, 1'b0, 1'b1);
        // pad count larger than the held bytes -> check fails, both released
        put_item(8'h03, 1'b1, 1'b0);
        put_item(8'h03, 1'b1, 1'b1);
        // single-byte pad after an all-ones byte
        put_item(8'hFF, 1'b1, 1'b0);
        put_item(8'h01, 1'b1, 1'b1);
        // block shrunk mid-message: oldest held bytes go out before the next push
        drain_results();
        apb_write(REG_BLOCK_BYTES, 6'd8);
        for (int i = 0; i < 6; i++)
            put_item(8'hA0 + 8'(i), 1'b1, 1'b0);
        drain_results();
        apb_write(REG_BLOCK_BYTES, 6'd3);
        put_item(8'h01, 1'b1, 1'b1);
        // unpad start, pad finish: held byte is discarded
        put_item(8'h77, 1'b1, 1'b0);
        drain_results();
        apb_write(REG_PAD_MODE, 6'd0);
        put_item(8'h88, 1'b1, 1'b1);
        // pad start, unpad finish on an empty end: phase cleared, empty marker
        put_item(8'h99, 1'b1, 1'b0);
        drain_results();
        apb_write(REG_PAD_MODE, 6'd1);
        put_item(8'h00, 1'b0, 1'b1);
    endtask

    // One message with random content. In unpad mode most bodies carry a proper
    // pad run; the rest break it in one of several ways.
    task automatic random_message();
        logic [7:0] body[$];
        int         len;
        int         b;
        int         p;
        int         r;
        int         cut;
        bit         empty_end;
        shape_t     shape;
        b = sb.eff_block();
        r = $urandom_range(0, 19);
        if (r < 15)
            len = $urandom_range(0, 10);
        else if (r < 19)
            len = $urandom_range(11, 40);
        else
            len = $urandom_range(41, 70);
        repeat (len) body.push_back(8'($urandom));
        if (sb.unpad)
        begin
            r = $urandom_range(0, 11);
            if (r < 7)
                shape = SH_GOOD;
            else if (r == 7)
                shape = SH_BAD_RUN;
            else if (r == 8)
                shape = SH_ZERO_COUNT;
            else if (r == 9)
                shape = SH_BIG_COUNT;
            else if (r == 10)
                shape = SH_SHORT_RUN;
            else
                shape = SH_RAW;
            p = $urandom_range(1, b);
            case (shape)
                SH_GOOD, SH_BAD_RUN:
                begin
                    repeat (p) body.push_back(8'(p));
                    // flip one byte of the run
                    if (shape == SH_BAD_RUN)
                        body[body.size() - 1 - $urandom_range(0, p - 1)] ^=
                            8'($urandom_range(1, 255));
                end
                SH_ZERO_COUNT: body.push_back(8'h00);
                SH_BIG_COUNT:  body.push_back(8'($urandom_range(b + 1, 255)));
                SH_SHORT_RUN:
                begin
                    // run of count p but only p-1 bytes in the whole message (a lone 01 when the block is 1)
                    body = {};
                    if (b >= 2)
                        p = $urandom_range(2, b);
                    repeat (p - 1) body.push_back(8'(p));
                    if (p == 1)
                        body.push_back(8'h01);
                end
                default: ;
            endcase
        end
        empty_end = (body.size() == 0) || ($urandom_range(0, 5) == 0);
        cut = (body.size() > 1 && $urandom_range(0, 9) == 0) ?
              $urandom_range(1, body.size() - 1) : -1;
        for (int i = 0; i < body.size(); i++)
        begin
            // pause mid-message and retune the core
            if (i == cut)
            begin
                drain_results();
                apb_write(REG_BLOCK_BYTES, pick_block());
                if ($urandom_range(0, 1) == 0)
                    apb_write(REG_PAD_MODE, 6'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 15) == 0)
                put_item(8'($urandom), 1'b0, 1'b0);
            put_item(body[i], 1'b1, !empty_end && (i == body.size() - 1));
        end
        if (empty_end)
            put_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // A phase: settle the core, set both registers, run a few messages.
    // The first phases pin the block size extremes in each mode.
    task automatic random_phase(input int idx);
        logic       mode;
        logic [5:0] blk;
        int         n;
        drain_results();
        case (idx)
            0:
            begin
                mode = 1'b1;
                blk  = 6'd1;
            end
            1:
            begin
                mode = 1'b1;
                blk  = 6'd32;
            end
            2:
            begin
                mode = 1'b0;
                blk  = 6'd1;
            end
            3:
            begin
                mode = 1'b0;
                blk  = 6'd32;
            end
            default:
            begin
                mode = ($urandom_range(0, 2) != 0);
                blk  = pick_block();
            end
        endcase
        steady = ($urandom_range(0, 3) == 0);
        apb_write(REG_PAD_MODE, {5'b0, mode});
        apb_write(REG_BLOCK_BYTES, blk);
        n = $urandom_range(2, 6);
        repeat (n) random_message();
    endtask

    initial
    begin
        int idx;
        // hold every input at a known value from time zero
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        msg_if.valid      = 1'b0;
        msg_if.data_in    = '0;
        msg_if.byte_valid = 1'b0;
        msg_if.msg_end    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        // random phases until at least 360 message transfers, directed ones included, have gone in
        idx = 0;
        while (sent < 360)
        begin
            random_phase(idx);
            idx++;
        end

        drain_results();
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("PASS pkcs7_pad_unpad_stream_core");
        else
            $display("FAIL pkcs7_pad_unpad_stream_core");
        $finish;
    end

endmodule
